// ----- design/salc_pkg.sv -----
// ----------------------------------------------------------------------------
// Set-associative LRU cache model package
// Shared types, register indexes and helpers for the cache lookup block.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int ADDR_W  = 64;
  localparam int CNT_W   = 32;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] CMD_MODIFY = 2'd2;

  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS_USED  = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } salc_state_t;

  typedef struct packed {
    logic [4:0] set_bits;
    logic [4:0] block_bits;
    logic [4:0] ways;
  } salc_cfg_t;

  typedef struct packed {
    logic hit;
    logic evict;
  } salc_flags_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                               input logic [1:0] n);
    logic [CNT_W:0] sum;
    sum = {1'b0, v} + (CNT_W + 1)'(n);
    return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  endfunction

endpackage

// ----- design/salc_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// Synchronous write and registered read.
// ----------------------------------------------------------------------------
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/salc_cfg.sv -----
// ----------------------------------------------------------------------------
// Cache geometry registers
// APB register file for set bits, block bits and ways in use, with set bits and
// ways limited to what the configured storage supports.
// ----------------------------------------------------------------------------
module salc_cfg #(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [salc_pkg::PADDR_W-1:0]   paddr,
  input  logic [salc_pkg::PDATA_W-1:0]   pwdata,
  output logic [salc_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output salc_pkg::salc_cfg_t            cfg
);
  import salc_pkg::*;

  localparam int SMAX = $clog2(MAX_SETS + 1) - 1;

  logic [3:0] set_bits;
  logic [4:0] block_bits;
  logic [3:0] ways_used;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits   <= 4'd0;
      block_bits <= 5'd0;
      ways_used  <= 4'd1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SET_BITS:   set_bits   <= pwdata[3:0];
        REG_BLOCK_BITS: block_bits <= pwdata[4:0];
        REG_WAYS_USED:  ways_used  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SET_BITS:   prdata = PDATA_W'(set_bits);
      REG_BLOCK_BITS: prdata = PDATA_W'(block_bits);
      REG_WAYS_USED:  prdata = PDATA_W'(ways_used);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    cfg.block_bits = block_bits;
    if ({1'b0, set_bits} > 5'(SMAX)) begin
      cfg.set_bits = 5'(SMAX);
    end else begin
      cfg.set_bits = {1'b0, set_bits};
    end
    if (ways_used == 4'd0) begin
      cfg.ways = 5'd1;
    end else if ({1'b0, ways_used} > 5'(MAX_WAYS)) begin
      cfg.ways = 5'(MAX_WAYS);
    end else begin
      cfg.ways = {1'b0, ways_used};
    end
  end

endmodule

// ----- design/salc_update.sv -----
// ----------------------------------------------------------------------------
// Set lookup and LRU update
// Compares the ways in use of one set, picks the hit, fill or victim way, and
// builds the written-back row with refreshed recency ranks.
// ----------------------------------------------------------------------------
module salc_update #(
  parameter int MAX_WAYS = 8,
  localparam int RW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
  input  logic [MAX_WAYS-1:0]                        valid,
  input  logic [MAX_WAYS-1:0][salc_pkg::ADDR_W-1:0]  tags,
  input  logic [MAX_WAYS-1:0][RW-1:0]                ranks,
  input  logic [salc_pkg::ADDR_W-1:0]                tag,
  input  logic [4:0]                                 ways,
  output salc_pkg::salc_flags_t                      flags,
  output logic [MAX_WAYS-1:0]                        new_valid,
  output logic [MAX_WAYS-1:0][salc_pkg::ADDR_W-1:0]  new_tags,
  output logic [MAX_WAYS-1:0][RW-1:0]                new_ranks
);
  import salc_pkg::*;

  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] match;
  logic [MAX_WAYS-1:0] inval;
  logic [WW-1:0]       hit_way;
  logic [WW-1:0]       inv_way;
  logic [WW-1:0]       lru_way;
  logic [WW-1:0]       sel_way;
  logic [RW-1:0]       lru_rank;
  logic [RW-1:0]       tgt_rank;
  logic                have_lru;
  logic                tgt_valid;

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i] = 5'(i) < ways;
      match[i]  = in_use[i] && valid[i] && (tags[i] == tag);
      inval[i]  = in_use[i] && !valid[i];
    end
  end

  always_comb begin
    hit_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_way = WW'(i);
      end
    end
    inv_way = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (inval[i]) begin
        inv_way = WW'(i);
      end
    end
    lru_way  = '0;
    lru_rank = '0;
    have_lru = 1'b0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (in_use[i] && valid[i] && (!have_lru || ranks[i] > lru_rank)) begin
        have_lru = 1'b1;
        lru_rank = ranks[i];
        lru_way  = WW'(i);
      end
    end
  end

  always_comb begin
    flags.hit   = |match;
    flags.evict = !(|match) && !(|inval);
    if (|match) begin
      sel_way = hit_way;
    end else if (|inval) begin
      sel_way = inv_way;
    end else begin
      sel_way = lru_way;
    end
  end

  assign tgt_valid = valid[sel_way];
  assign tgt_rank  = ranks[sel_way];

  always_comb begin
    new_valid = valid;
    new_tags  = tags;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (WW'(i) == sel_way) begin
        new_ranks[i] = '0;
      end else if (valid[i] && (!tgt_valid || ranks[i] < tgt_rank)) begin
        new_ranks[i] = ranks[i] + RW'(1);
      end else begin
        new_ranks[i] = ranks[i];
      end
    end
    new_valid[sel_way] = 1'b1;
    new_tags[sel_way]  = tag;
  end

endmodule

// ----- design/set_assoc_lru_cache_sim.sv -----
// ----------------------------------------------------------------------------
// Set-associative LRU cache simulator
// An access beat is taken when start is high and busy is low; cmd and addr
// carry the access kind and the byte address. The set row is read from the
// line RAM in the cycle after the beat, compared over all ways at once, and
// written back at the end of that cycle. The result beat (done high for one
// cycle, with hit, miss, eviction, modify_hit and the running totals) shows
// in the cycle after the write-back. busy is high in the lookup cycle, so a
// new access is taken only after the previous one has been written back.
// The receiver has no way to stall results; each result beat is valid for
// exactly one cycle. After reset the block clears all MAX_SETS sets of the
// line RAM, one set per cycle, with busy high; configuration writes are taken
// as usual during that pass. The geometry registers sit on the APB port at
// byte addresses 0, 4 and 8 and should only be written while the block is
// idle.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim #(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     cmd,
  input  logic [salc_pkg::ADDR_W-1:0]    addr,
  output logic                           done,
  output logic                           hit,
  output logic                           miss,
  output logic                           eviction,
  output logic                           modify_hit,
  output logic [salc_pkg::CNT_W-1:0]     total_hits,
  output logic [salc_pkg::CNT_W-1:0]     total_misses,
  output logic [salc_pkg::CNT_W-1:0]     total_evictions,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [salc_pkg::PADDR_W-1:0]   paddr,
  input  logic [salc_pkg::PDATA_W-1:0]   pwdata,
  output logic [salc_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import salc_pkg::*;

  localparam int AW    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int RW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int ROW_W = MAX_WAYS * (1 + ADDR_W + RW);

  salc_cfg_t   cfg;
  salc_flags_t flags;
  salc_state_t state;
  salc_state_t state_next;

  logic [AW-1:0]       clr_idx;
  logic                clr_last;
  logic                accept;
  logic                clearing;
  logic                finishing;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [ROW_W-1:0]    ram_wdata;
  logic [ROW_W-1:0]    ram_rdata;
  logic [AW-1:0]       in_set;
  logic [AW-1:0]       set_mask;
  logic [5:0]          tag_shift;
  logic [ADDR_W-1:0]   in_tag;
  logic [ADDR_W-1:0]   in_idx_full;
  logic [AW-1:0]       set_q;
  logic [ADDR_W-1:0]   tag_q;
  logic                mod_q;

  logic [MAX_WAYS-1:0]               rd_valid;
  logic [MAX_WAYS-1:0][ADDR_W-1:0]   rd_tags;
  logic [MAX_WAYS-1:0][RW-1:0]       rd_ranks;
  logic [MAX_WAYS-1:0]               wr_valid;
  logic [MAX_WAYS-1:0][ADDR_W-1:0]   wr_tags;
  logic [MAX_WAYS-1:0][RW-1:0]       wr_ranks;

  salc_cfg #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign tag_shift   = 6'(cfg.set_bits) + 6'(cfg.block_bits);
  assign in_tag      = addr >> tag_shift;
  assign in_idx_full = addr >> cfg.block_bits;
  assign set_mask    = ~({AW{1'b1}} << cfg.set_bits);
  assign in_set      = in_idx_full[AW-1:0] & set_mask;

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_set),
    .rdata (ram_rdata)
  );

  assign {rd_valid, rd_tags, rd_ranks} = ram_rdata;

  salc_update #(
    .MAX_WAYS (MAX_WAYS)
  ) u_update (
    .valid     (rd_valid),
    .tags      (rd_tags),
    .ranks     (rd_ranks),
    .tag       (tag_q),
    .ways      (cfg.ways),
    .flags     (flags),
    .new_valid (wr_valid),
    .new_tags  (wr_tags),
    .new_ranks (wr_ranks)
  );

  assign clr_last  = clr_idx == AW'(MAX_SETS - 1);
  assign ram_waddr = clearing ? clr_idx : set_q;
  assign ram_wdata = clearing ? '0 : {wr_valid, wr_tags, wr_ranks};

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  state_next = clr_last ? ST_IDLE : ST_CLEAR;
      ST_IDLE:   state_next = start ? ST_LOOKUP : ST_IDLE;
      ST_LOOKUP: state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    clearing  = 1'b0;
    finishing = 1'b0;
    case (state)
      ST_CLEAR:  clearing  = 1'b1;
      ST_IDLE:   busy      = 1'b0;
      ST_LOOKUP: finishing = 1'b1;
      default:   clearing  = 1'b0;
    endcase
    accept = start && !busy;
    ram_we = clearing || finishing;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      clr_idx         <= '0;
      done            <= 1'b0;
      total_hits      <= '0;
      total_misses    <= '0;
      total_evictions <= '0;
    end else begin
      state <= state_next;
      done  <= finishing;
      if (clearing) begin
        clr_idx <= clr_idx + AW'(1);
      end
      if (finishing) begin
        total_hits      <= sat_add(total_hits, {1'b0, flags.hit} + {1'b0, mod_q});
        total_misses    <= sat_add(total_misses, {1'b0, !flags.hit});
        total_evictions <= sat_add(total_evictions, {1'b0, flags.evict});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_q <= in_set;
      tag_q <= in_tag;
      mod_q <= cmd == CMD_MODIFY;
    end
    if (finishing) begin
      hit        <= flags.hit;
      miss       <= !flags.hit;
      eviction   <= flags.evict;
      modify_hit <= mod_q;
    end
  end

endmodule

// ----- design/salc_chk.sv -----
// ----------------------------------------------------------------------------
// Cache simulator port checker
// Timing and result consistency checks on the top-level ports.
// ----------------------------------------------------------------------------
module salc_chk (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic hit,
  input logic miss,
  input logic eviction
);

  a_result_timing: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("Result beat did not follow the access beat in time.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("Block was not busy after taking an access beat.");

  a_hit_xor_miss: assert property (@(posedge clk) disable iff (rst)
    done |-> (hit != miss))
    else $error("Result beat must report exactly one of hit and miss.");

  a_evict_on_miss: assert property (@(posedge clk) disable iff (rst)
    (done && eviction) |-> miss)
    else $error("Eviction reported without a miss.");

  a_single_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("Result beats came in adjacent cycles.");

endmodule

bind set_assoc_lru_cache_sim salc_chk u_salc_chk (.*);

// ----- sim/tb_set_assoc_lru_cache_sim.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the set-associative LRU cache simulator
// Drives load, store and modify accesses through the start/busy port. The
// cache geometry is programmed over APB between phases. Every result beat is
// checked against a cycle-free model of the sets, the recency ranks and the
// saturating totals. The stimulus starts with directed cases for the
// command codes, the field extremes, out-of-range register values and stale
// lines. Random traffic then follows, drawn mostly from small pools of tags
// so that hits, conflicts and evictions are frequent.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_sim;
  import salc_pkg::*;

  localparam int MAX_SETS        = 256;
  localparam int MAX_WAYS        = 8;
  localparam int LINES           = MAX_SETS * MAX_WAYS;
  localparam int SET_BITS_CAP    = $clog2(MAX_SETS);
  localparam int CYCLE_LIMIT     = 400000;
  localparam int END_CYCLES      = 4;
  localparam int RANDOM_SEGMENTS = 16;
  localparam int SEGMENT_ITEMS   = 100;
  localparam int POOL_SIZE       = 10;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_STORE  = 2'd1;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic             hit;
    logic             miss;
    logic             eviction;
    logic             modify_hit;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] evictions;
  } access_outcome_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          cmd = CMD_LOAD;
  logic [ADDR_W-1:0]   addr = '0;
  logic                done;
  logic                hit;
  logic                miss;
  logic                eviction;
  logic                modify_hit;
  logic [CNT_W-1:0]    total_hits;
  logic [CNT_W-1:0]    total_misses;
  logic [CNT_W-1:0]    total_evictions;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  logic [3:0]          cfg_set_bits = 4'd0;
  logic [4:0]          cfg_block_bits = 5'd0;
  logic [3:0]          cfg_ways = 4'd1;
  logic                line_ok [LINES];
  logic [ADDR_W-1:0]   line_tag_mem [LINES];
  logic [2:0]          line_age [LINES];
  logic [CNT_W-1:0]    n_hits = '0;
  logic [CNT_W-1:0]    n_misses = '0;
  logic [CNT_W-1:0]    n_evictions = '0;

  access_outcome_t     outcome_q [$];
  access_outcome_t     oldest;
  int                  mismatches = 0;
  int                  cycle_count = 0;
  int                  sender_idle_pct = 7;

  set_assoc_lru_cache_sim #(
    .MAX_SETS(MAX_SETS),
    .MAX_WAYS(MAX_WAYS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .addr(addr),
    .done(done),
    .hit(hit),
    .miss(miss),
    .eviction(eviction),
    .modify_hit(modify_hit),
    .total_hits(total_hits),
    .total_misses(total_misses),
    .total_evictions(total_evictions),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < LINES; i++) begin
      line_ok[i] = 1'b0;
      line_tag_mem[i] = '0;
      line_age[i] = 3'd0;
    end
  end

  function automatic logic [CNT_W-1:0] bump_count(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic int index_bits();
    return (int'(cfg_set_bits) > SET_BITS_CAP) ? SET_BITS_CAP : int'(cfg_set_bits);
  endfunction

  function automatic int ways_in_use();
    if (cfg_ways == 4'd0) begin
      return 1;
    end
    return (int'(cfg_ways) > MAX_WAYS) ? MAX_WAYS : int'(cfg_ways);
  endfunction

  task automatic promote_line(input int base, input int w);
    int r;
    r = line_ok[base + w] ? int'(line_age[base + w]) : 'hFFFF;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (i != w && line_ok[base + i] && int'(line_age[base + i]) < r) begin
        line_age[base + i] = line_age[base + i] + 3'd1;
      end
    end
    line_age[base + w] = 3'd0;
  endtask

  task automatic cache_access(input logic [1:0] c, input logic [ADDR_W-1:0] a,
                              output access_outcome_t o);
    int s;
    int b;
    int ways;
    int base;
    int hit_way;
    int inv_way;
    int lru_way;
    int victim;
    logic found;
    logic found_inv;
    logic have_lru;
    logic evicted;
    logic [2:0] lru_rank;
    logic [ADDR_W-1:0] tag;
    s = index_bits();
    b = int'(cfg_block_bits);
    ways = ways_in_use();
    tag = a >> (s + b);
    base = int'((a >> b) & ((64'd1 << s) - 64'd1)) * MAX_WAYS;
    found = 1'b0;
    found_inv = 1'b0;
    have_lru = 1'b0;
    evicted = 1'b0;
    hit_way = 0;
    inv_way = 0;
    lru_way = 0;
    lru_rank = 3'd0;
    for (int i = 0; i < ways && !found; i++) begin
      if (line_ok[base + i] && line_tag_mem[base + i] == tag) begin
        found = 1'b1;
        hit_way = i;
      end else if (!line_ok[base + i]) begin
        found_inv = 1'b1;
        inv_way = i;
      end else if (!have_lru || line_age[base + i] > lru_rank) begin
        have_lru = 1'b1;
        lru_rank = line_age[base + i];
        lru_way = i;
      end
    end
    if (found) begin
      promote_line(base, hit_way);
      n_hits = bump_count(n_hits);
    end else begin
      victim = found_inv ? inv_way : lru_way;
      n_misses = bump_count(n_misses);
      if (!found_inv) begin
        evicted = 1'b1;
        n_evictions = bump_count(n_evictions);
      end
      promote_line(base, victim);
      line_ok[base + victim] = 1'b1;
      line_tag_mem[base + victim] = tag;
    end
    if (c == CMD_MODIFY) begin
      n_hits = bump_count(n_hits);
    end
    o.hit = found;
    o.miss = !found;
    o.eviction = evicted;
    o.modify_hit = (c == CMD_MODIFY);
    o.hits = n_hits;
    o.misses = n_misses;
    o.evictions = n_evictions;
  endtask

  task automatic access_beat(input logic [1:0] c, input logic [ADDR_W-1:0] a);
    access_outcome_t o;
    start <= 1'b1;
    cmd <= c;
    addr <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    cache_access(c, a, o);
    outcome_q.push_back(o);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_SET_BITS:   cfg_set_bits = value[3:0];
      REG_BLOCK_BITS: cfg_block_bits = value[4:0];
      REG_WAYS_USED:  cfg_ways = value[3:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int s, input int b, input int w);
    drain_results();
    write_reg(REG_SET_BITS, PDATA_W'(s));
    write_reg(REG_BLOCK_BITS, PDATA_W'(b));
    write_reg(REG_WAYS_USED, PDATA_W'(w));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [ADDR_W-1:0] line_addr(input logic [ADDR_W-1:0] tag,
                                                 input int set_idx,
                                                 input logic [ADDR_W-1:0] offset);
    int s;
    int b;
    s = index_bits();
    b = int'(cfg_block_bits);
    return (tag << (s + b)) | ((ADDR_W'(set_idx) & ((64'd1 << s) - 64'd1)) << b) |
           (offset & ((64'd1 << b) - 64'd1));
  endfunction

  task automatic test_reset_defaults();
    access_beat(CMD_LOAD, 64'd0);
    access_beat(CMD_LOAD, 64'd0);
    access_beat(CMD_STORE, {ADDR_W{1'b1}});
    access_beat(CMD_MODIFY, {ADDR_W{1'b1}});
    access_beat(CMD_UNUSED, 64'd0);
  endtask

  task automatic test_access_kinds();
    set_geometry(2, 4, 2);
    access_beat(CMD_STORE, line_addr(64'd1, 0, 64'd5));
    access_beat(CMD_LOAD, line_addr(64'd2, 0, 64'd0));
    access_beat(CMD_LOAD, line_addr(64'd1, 0, 64'd15));
    access_beat(CMD_LOAD, line_addr(64'd3, 0, 64'd0));
    access_beat(CMD_MODIFY, line_addr(64'd2, 0, 64'd9));
    access_beat(CMD_UNUSED, line_addr(64'd1, 0, 64'd0));
  endtask

  task automatic test_field_extremes();
    set_geometry(15, 31, 8);
    access_beat(CMD_LOAD, 64'd0);
    access_beat(CMD_LOAD, {ADDR_W{1'b1}});
    access_beat(CMD_STORE, 64'h8000_0000_0000_0000);
    access_beat(CMD_MODIFY, {ADDR_W{1'b1}});
    set_geometry(8, 16, 8);
    access_beat(CMD_LOAD, {ADDR_W{1'b1}});
    access_beat(CMD_LOAD, {ADDR_W{1'b1}} ^ (64'd1 << 16));
  endtask

  task automatic test_ways_edges();
    set_geometry(2, 0, 2);
    access_beat(CMD_LOAD, line_addr(64'd9, 3, 64'd0));
    set_geometry(2, 0, 1);
    access_beat(CMD_LOAD, line_addr(64'd9, 3, 64'd0));
    set_geometry(2, 0, 2);
    access_beat(CMD_LOAD, line_addr(64'd9, 3, 64'd0));
    access_beat(CMD_LOAD, line_addr(64'd11, 3, 64'd0));
    set_geometry(2, 0, 0);
    access_beat(CMD_LOAD, line_addr(64'd12, 3, 64'd0));
    set_geometry(2, 0, 15);
    access_beat(CMD_LOAD, line_addr(64'd9, 3, 64'd0));
    access_beat(CMD_STORE, line_addr(64'd13, 3, 64'd0));
  endtask

  task automatic test_random_traffic();
    logic [ADDR_W-1:0] tag_pool [POOL_SIZE];
    int n_tags;
    logic [1:0] c;
    logic [ADDR_W-1:0] a;
    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      sender_idle_pct = (seg < 6) ? 7 : ((seg < 11) ? 62 : 0);
      case (seg)
        0: set_geometry(8, 16, 8);
        1: set_geometry(15, 31, 15);
        2: set_geometry(0, 0, 0);
        3: set_geometry(1, 2, 3);
        default: set_geometry($urandom_range(0, 15), $urandom_range(0, 31),
                              $urandom_range(0, 15));
      endcase
      for (int k = 0; k < POOL_SIZE; k++) begin
        tag_pool[k] = $urandom_range(0, 1) ? ADDR_W'($urandom_range(0, 15))
                                           : {$urandom, $urandom};
      end
      n_tags = ways_in_use() + 1 + $urandom_range(0, 2);
      if (n_tags > POOL_SIZE) begin
        n_tags = POOL_SIZE;
      end
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        c = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 15) begin
          a = {$urandom, $urandom};
        end else begin
          a = line_addr(tag_pool[$urandom_range(0, n_tags - 1)], $urandom_range(0, 3),
                        {$urandom, $urandom});
        end
        access_beat(c, a);
      end
    end
  endtask

  task automatic check_field(input string field, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, field, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (outcome_q.size() == 0) begin
        mismatches++;
        $display("%0t: done expected 0 actual %0h", $time, done);
      end else begin
        oldest = outcome_q.pop_front();
        check_field("hit", oldest.hit, hit);
        check_field("miss", oldest.miss, miss);
        check_field("eviction", oldest.eviction, eviction);
        check_field("modify_hit", oldest.modify_hit, modify_hit);
        check_field("total_hits", oldest.hits, total_hits);
        check_field("total_misses", oldest.misses, total_misses);
        check_field("total_evictions", oldest.evictions, total_evictions);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_access_kinds();
    test_field_extremes();
    test_ways_edges();
    test_random_traffic();
    drain_results();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/salc_pkg.sv
design/salc_ram.sv
design/salc_cfg.sv
design/salc_update.sv
design/set_assoc_lru_cache_sim.sv
design/salc_chk.sv
sim/tb_set_assoc_lru_cache_sim.sv
